/* src/rct_pkg.sv */
// shared types, codes and defaults for the reference count table
package rct_pkg;

    localparam int ENTRIES_DEFAULT = 256;
    localparam int ID_W            = 32;
    localparam int CNT_W           = 32;
    localparam int STATUS_W        = 3;
    localparam int PADDR_W         = 3;

    // register index of the enable register
    localparam logic REG_ENABLED = 1'b0;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_ADD      = 2'd1,
        OP_RELEASE  = 2'd2,
        OP_LOOKUP   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 3'd0,
        STATUS_NOINIT   = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_NOTFOUND = 3'd3,
        STATUS_DOUBLE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

/* src/reference_count_table_unit.sv */
// reference count table: one entry read per cycle, first hit is updated in place
// flow: an accepted item scans from slot 0 until a hit, or through all ENTRIES slots on a
//   miss, then enters the finish state; a disabled manager skips the scan entirely
// one item at a time: item_stall stays high from acceptance until the result is loaded
// reset: table inactive, error counter zero, manager disabled; writing enabled=1 clears both
//   at once through the active flops, no clearing pass
module reference_count_table_unit #(
    parameter int ENTRIES = rct_pkg::ENTRIES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rct_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // item channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [1:0]                   op,
    input  logic [rct_pkg::ID_W-1:0]     rsrc_id,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [rct_pkg::STATUS_W-1:0] status,
    output logic [rct_pkg::CNT_W-1:0]    count,
    output logic [rct_pkg::CNT_W-1:0]    error_total
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ROW_W = rct_pkg::ID_W + rct_pkg::CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    rct_pkg::state_t state_reg, state_next;

    logic                         enabled_reg;
    logic [ENTRIES-1:0]           active_reg, active_next;
    logic [rct_pkg::CNT_W-1:0]    err_reg, err_next;
    logic [IDX_W-1:0]             scan_reg, scan_next;
    rct_pkg::op_t                 op_reg, op_next;
    logic [rct_pkg::ID_W-1:0]     id_reg, id_next;

    // pending result waiting for the output register
    rct_pkg::status_t             res_status_reg, res_status_next;
    logic [rct_pkg::CNT_W-1:0]    res_count_reg, res_count_next;

    logic                         out_valid_reg;
    rct_pkg::status_t             out_status_reg;
    logic [rct_pkg::CNT_W-1:0]    out_count_reg;
    logic [rct_pkg::CNT_W-1:0]    out_err_reg;

    logic                         cfg_write;
    logic                         cfg_enable_set;
    logic                         item_take;
    logic                         out_free;
    logic                         out_load;

    logic                         wr_en;
    logic [ROW_W-1:0]             wr_data;
    logic [IDX_W-1:0]             rd_addr;
    logic [ROW_W-1:0]             rd_data;
    logic [rct_pkg::ID_W-1:0]     cur_id;
    logic [rct_pkg::CNT_W-1:0]    cur_count;
    logic [rct_pkg::CNT_W-1:0]    cnt_dec;
    logic                         hit;

    assign pready    = 1'b1;
    assign prdata    = {31'd0, enabled_reg};
    assign cfg_write = psel && penable && pwrite && (paddr[2] == rct_pkg::REG_ENABLED);
    assign cfg_enable_set = cfg_write && pwdata[0];

    assign item_stall = (state_reg != rct_pkg::ST_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;
    assign out_load   = (state_reg == rct_pkg::ST_FINISH) && out_free;

    assign cur_id    = rd_data[ROW_W-1:rct_pkg::CNT_W];
    assign cur_count = rd_data[rct_pkg::CNT_W-1:0];
    assign cnt_dec   = cur_count - rct_pkg::CNT_W'(1);

    // prefetch the next slot while the current one is checked
    assign rd_addr = (state_reg == rct_pkg::ST_SCAN && scan_reg != LAST_IDX)
                     ? scan_reg + IDX_W'(1) : '0;

    rct_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ROW_W),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (scan_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (op_reg == rct_pkg::OP_REGISTER)
        begin
            hit = !active_reg[scan_reg];
        end
        else
        begin
            hit = active_reg[scan_reg] && (cur_id == id_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        err_next        = err_reg;
        scan_next       = scan_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        wr_en           = 1'b0;
        wr_data         = {id_reg, cur_count};

        unique case (state_reg)
            rct_pkg::ST_IDLE:
            begin
                if (item_take)
                begin
                    op_next        = rct_pkg::op_t'(op);
                    id_next        = rsrc_id;
                    scan_next      = '0;
                    res_count_next = '0;
                    if (enabled_reg)
                    begin
                        state_next = rct_pkg::ST_SCAN;
                    end
                    else
                    begin
                        res_status_next = rct_pkg::STATUS_NOINIT;
                        state_next      = rct_pkg::ST_FINISH;
                    end
                end
            end

            rct_pkg::ST_SCAN:
            begin
                res_status_next = rct_pkg::STATUS_OK;
                res_count_next  = '0;
                if (hit)
                begin
                    state_next = rct_pkg::ST_FINISH;
                    case (op_reg)
                        rct_pkg::OP_REGISTER:
                        begin
                            wr_en                 = 1'b1;
                            wr_data               = {id_reg, rct_pkg::CNT_W'(1)};
                            active_next[scan_reg] = 1'b1;
                        end
                        rct_pkg::OP_ADD:
                        begin
                            wr_en   = 1'b1;
                            wr_data = {id_reg, cur_count + rct_pkg::CNT_W'(1)};
                        end
                        rct_pkg::OP_RELEASE:
                        begin
                            if (cur_count == '0)
                            begin
                                res_status_next = rct_pkg::STATUS_DOUBLE;
                                err_next        = err_reg + rct_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_data        = {id_reg, cnt_dec};
                                res_count_next = cnt_dec;
                                if (cnt_dec == '0)
                                begin
                                    active_next[scan_reg] = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            res_count_next = cur_count;
                        end
                    endcase
                end
                else if (scan_reg == LAST_IDX)
                begin
                    state_next = rct_pkg::ST_FINISH;
                    case (op_reg)
                        rct_pkg::OP_REGISTER:
                        begin
                            res_status_next = rct_pkg::STATUS_FULL;
                        end
                        rct_pkg::OP_ADD, rct_pkg::OP_RELEASE:
                        begin
                            res_status_next = rct_pkg::STATUS_NOTFOUND;
                            err_next        = err_reg + rct_pkg::CNT_W'(1);
                        end
                        default:
                        begin
                            res_status_next = rct_pkg::STATUS_NOTFOUND;
                        end
                    endcase
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end

            rct_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = rct_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rct_pkg::ST_IDLE;
            end
        endcase

        // enable write wipes the table; the user must issue it only while idle (unchecked)
        if (cfg_enable_set)
        begin
            active_next = '0;
            err_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rct_pkg::ST_IDLE;
            enabled_reg   <= 1'b0;
            active_reg    <= '0;
            err_reg       <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            err_reg    <= err_next;
            scan_reg   <= scan_next;
            if (cfg_write)
            begin
                enabled_reg <= pwdata[0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= res_count_reg;
            out_err_reg    <= err_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign count        = out_count_reg;
    assign error_total  = out_err_reg;

    // the scan walks one slot per cycle
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rct_pkg::ST_SCAN && $past(state_reg) == rct_pkg::ST_SCAN)
        |-> scan_reg == $past(scan_reg) + IDX_W'(1))
        else $error("scan index did not advance by one");

    // a finished item reaches the output as soon as the slot is free
    a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rct_pkg::ST_FINISH && out_free)
        |=> state_reg == rct_pkg::ST_IDLE && out_valid_reg)
        else $error("finished result not loaded");

    // not-initialized results never carry a count
    a_noinit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == rct_pkg::STATUS_NOINIT) |-> out_count_reg == '0)
        else $error("count on a not-initialized result");

endmodule

/* src/rct_ram.sv */
// entry memory: one write port, one registered read port
module rct_ram #(
    parameter int DEPTH = rct_pkg::ENTRIES_DEFAULT,
    parameter int WIDTH = rct_pkg::ID_W + rct_pkg::CNT_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/sv/tb_reference_count_table_unit.sv */
`timescale 1ns / 100ps
// testbench for the reference count table unit: directed and random ops checked beat by beat
module tb_reference_count_table_unit;

    localparam int TABLE_SIZE     = rct_pkg::ENTRIES_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4 * (TABLE_SIZE + 16);
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 210;

    typedef struct packed {
        rct_pkg::status_t          status;
        logic [rct_pkg::CNT_W-1:0] count;
        logic [rct_pkg::CNT_W-1:0] error_total;
    } table_result_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic [rct_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [31:0]                  pwdata       = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         item_valid   = 1'b0;
    logic                         item_stall;
    logic [1:0]                   op           = rct_pkg::OP_REGISTER;
    logic [rct_pkg::ID_W-1:0]     rsrc_id      = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic [rct_pkg::STATUS_W-1:0] status;
    logic [rct_pkg::CNT_W-1:0]    count;
    logic [rct_pkg::CNT_W-1:0]    error_total;

    // table model
    logic [rct_pkg::ID_W-1:0]     slot_id     [TABLE_SIZE];
    logic [rct_pkg::CNT_W-1:0]    slot_count  [TABLE_SIZE];
    logic                         slot_active [TABLE_SIZE];
    logic [rct_pkg::CNT_W-1:0]    err_tally;
    logic                         mgr_enabled;

    table_result_t       outcomes_due [$];
    table_result_t       head_result;
    int                  fail_count    = 0;
    int                  items_sent    = 0;
    int                  beats_checked = 0;
    int                  status_tally [5];
    logic                no_idle       = 1'b0;
    int                  res_wait      = 0;
    int                  quiet_cycles  = 0;

    reference_count_table_unit #(
        .ENTRIES(TABLE_SIZE)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .op(op),
        .rsrc_id(rsrc_id),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .status(status),
        .count(count),
        .error_total(error_total)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_table_model();
        int i;
        for (i = 0; i < TABLE_SIZE; i++)
        begin
            slot_id[i]     = '0;
            slot_count[i]  = '0;
            slot_active[i] = 1'b0;
        end
        err_tally = '0;
    endfunction

    function automatic table_result_t compute_outcome(rct_pkg::op_t kind,
                                                      logic [rct_pkg::ID_W-1:0] id);
        table_result_t r;
        int            hit;
        int            i;
        r.status = rct_pkg::STATUS_OK;
        r.count  = '0;
        hit      = -1;
        if (!mgr_enabled)
        begin
            r.status = rct_pkg::STATUS_NOINIT;
        end
        else if (kind == rct_pkg::OP_REGISTER)
        begin
            // scan from the top so the lowest free slot wins
            for (i = TABLE_SIZE - 1; i >= 0; i--)
                if (!slot_active[i])
                    hit = i;
            if (hit < 0)
            begin
                r.status = rct_pkg::STATUS_FULL;
            end
            else
            begin
                slot_id[hit]     = id;
                slot_count[hit]  = 1;
                slot_active[hit] = 1'b1;
            end
        end
        else
        begin
            for (i = TABLE_SIZE - 1; i >= 0; i--)
                if (slot_active[i] && slot_id[i] == id)
                    hit = i;
            if (hit < 0)
            begin
                r.status = rct_pkg::STATUS_NOTFOUND;
                if (kind != rct_pkg::OP_LOOKUP)
                    err_tally = err_tally + 1;
            end
            else if (kind == rct_pkg::OP_ADD)
            begin
                slot_count[hit] = slot_count[hit] + 1;
            end
            else if (kind == rct_pkg::OP_LOOKUP)
            begin
                r.count = slot_count[hit];
            end
            else if (slot_count[hit] == 0)
            begin
                // wrapped count on a live slot
                r.status  = rct_pkg::STATUS_DOUBLE;
                err_tally = err_tally + 1;
            end
            else
            begin
                slot_count[hit] = slot_count[hit] - 1;
                r.count         = slot_count[hit];
                if (r.count == 0)
                    slot_active[hit] = 1'b0;
            end
        end
        r.error_total = err_tally;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // result side: check each beat, then hold stall for a drawn number of valid cycles
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            beats_checked++;
            if (outcomes_due.size() == 0)
            begin
                $display({"%0t: unexpected result beat, expected none, ",
                          "actual status %0d count %0h errors %0h"},
                         $time, status, count, error_total);
                fail_count++;
            end
            else
            begin
                head_result = outcomes_due.pop_front();
                status_tally[int'(head_result.status)]++;
                check_field("status", 32'(head_result.status), 32'(status));
                check_field("count", head_result.count, count);
                check_field("error_total", head_result.error_total, error_total);
            end
            res_wait = no_idle ? 0 : $urandom_range(0, 4);
        end
        else if (result_valid && res_wait > 0)
        begin
            res_wait--;
        end
        result_stall <= (res_wait > 0);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, %0d cycles without a beat", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // leaves valid high at the accepting edge so a gapless next beat needs no second assignment
    task automatic send_item(rct_pkg::op_t kind, logic [rct_pkg::ID_W-1:0] id);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= kind;
        rsrc_id    <= id;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        outcomes_due.push_back(compute_outcome(kind, id));
        items_sent++;
    endtask

    task automatic drain_items();
        item_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    // upper data bits are don't-care for the enable register
    task automatic write_enabled(logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rct_pkg::REG_ENABLED, 2'b00};
        pwdata  <= {31'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (value)
            clear_table_model();
        mgr_enabled = value;
    endtask

    task automatic test_disabled_ops();
        drain_items();
        write_enabled(1'b0);
        send_item(rct_pkg::OP_REGISTER, 32'h0000_0000);
        send_item(rct_pkg::OP_ADD, 32'hFFFF_FFFF);
        send_item(rct_pkg::OP_RELEASE, 32'h0000_0000);
        send_item(rct_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
    endtask

    task automatic test_basic_ops();
        drain_items();
        write_enabled(1'b1);
        send_item(rct_pkg::OP_REGISTER, 32'h0000_0000);
        send_item(rct_pkg::OP_REGISTER, 32'hFFFF_FFFF);
        send_item(rct_pkg::OP_ADD, 32'hFFFF_FFFF);
        send_item(rct_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
        send_item(rct_pkg::OP_RELEASE, 32'hFFFF_FFFF);
        send_item(rct_pkg::OP_RELEASE, 32'hFFFF_FFFF);
        send_item(rct_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
        send_item(rct_pkg::OP_ADD, 32'hFFFF_FFFF);
        send_item(rct_pkg::OP_RELEASE, 32'h5A5A_A5A5);
        // duplicate id goes into the freed slot, the lower one matches first
        send_item(rct_pkg::OP_REGISTER, 32'h0000_0000);
        send_item(rct_pkg::OP_ADD, 32'h0000_0000);
        send_item(rct_pkg::OP_RELEASE, 32'h0000_0000);
        send_item(rct_pkg::OP_RELEASE, 32'h0000_0000);
        send_item(rct_pkg::OP_LOOKUP, 32'h0000_0000);
        send_item(rct_pkg::OP_REGISTER, 32'hA5A5_5A5A);
        send_item(rct_pkg::OP_LOOKUP, 32'hA5A5_5A5A);
    endtask

    task automatic test_disable_keeps_errors();
        drain_items();
        write_enabled(1'b0);
        send_item(rct_pkg::OP_LOOKUP, 32'h0000_0000);
        send_item(rct_pkg::OP_ADD, 32'h1234_5678);
        send_item(rct_pkg::OP_RELEASE, 32'hA5A5_5A5A);
        drain_items();
        write_enabled(1'b1);
        send_item(rct_pkg::OP_LOOKUP, 32'h0000_0000);
        send_item(rct_pkg::OP_RELEASE, 32'hA5A5_5A5A);
    endtask

    task automatic test_table_full();
        int i;
        drain_items();
        // enable again while enabled, which clears
        write_enabled(1'b1);
        for (i = 0; i < TABLE_SIZE; i++)
            send_item(rct_pkg::OP_REGISTER, $urandom());
        send_item(rct_pkg::OP_REGISTER, 32'hDEAD_BEEF);
        send_item(rct_pkg::OP_ADD, 32'hDEAD_BEEF);
        send_item(rct_pkg::OP_RELEASE, slot_id[TABLE_SIZE / 2]);
        send_item(rct_pkg::OP_REGISTER, 32'hDEAD_BEEF);
        send_item(rct_pkg::OP_LOOKUP, slot_id[TABLE_SIZE - 1]);
        send_item(rct_pkg::OP_ADD, slot_id[TABLE_SIZE - 1]);
        send_item(rct_pkg::OP_REGISTER, $urandom());
    endtask

    task automatic test_random_traffic();
        logic [rct_pkg::ID_W-1:0] id_pool [12];
        int                       pool_n;
        int                       phase;
        int                       n;
        int                       pick;
        rct_pkg::op_t             kind;
        logic [rct_pkg::ID_W-1:0] id;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_items();
            if (phase % 3 == 2)
            begin
                // table and error counter stay put while disabled
                write_enabled(1'b0);
                for (n = 0; n < 12; n++)
                    send_item(rct_pkg::op_t'($urandom_range(0, 3)), $urandom());
                drain_items();
            end
            write_enabled(1'b1);
            pool_n     = $urandom_range(2, 12);
            id_pool[0] = 32'h0000_0000;
            id_pool[1] = 32'hFFFF_FFFF;
            for (n = 2; n < 12; n++)
                id_pool[n] = $urandom();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    kind = rct_pkg::OP_REGISTER;
                else if (pick < 45)
                    kind = rct_pkg::OP_ADD;
                else if (pick < 85)
                    kind = rct_pkg::OP_RELEASE;
                else
                    kind = rct_pkg::OP_LOOKUP;
                if ($urandom_range(0, 9) == 0)
                    id = $urandom();
                else
                    id = id_pool[$urandom_range(0, pool_n - 1)];
                send_item(kind, id);
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        clear_table_model();
        mgr_enabled = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled_ops();
        test_basic_ops();
        test_disable_keeps_errors();
        test_table_full();
        test_random_traffic();
        drain_items();
        repeat (TABLE_SIZE + 8) @(posedge clk);
        $display("sent %0d items, checked %0d result beats", items_sent, beats_checked);
        $display("ok %0d, not initialized %0d, table full %0d, not found %0d, double release %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
